// ----- hdl/ppt_pkg.sv -----
package ppt_pkg;

	localparam int TICKS_PER_SECOND = 1000;

	localparam int RATE_W    = 18;
	localparam int BUF_W     = 17;
	localparam int PER_W     = 16;
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 2;
	localparam int FUNC_W    = 2;
	localparam int TICKS_W   = 10;
	localparam int POS_W     = 16;
	localparam int PEND_W    = 16;
	localparam int REARM_W   = 26;
	localparam int FRAC_W    = 27;
	localparam int AMT_W     = 28;
	localparam int PFRAC_W   = 26;
	localparam int DVD_W     = 29;
	localparam int DVS_W     = 26;
	localparam int DIV_STEPS = DVD_W;
	localparam int DIV_CNT_W = 5;

	localparam logic [BUF_W-1:0]  BUF_MAX = BUF_W'(65536);

	localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE   = RATE_W'(8000);
	localparam logic [BUF_W-1:0]   RST_BUFFER_FRAMES = BUF_W'(32768);
	localparam logic [PER_W-1:0]   RST_PERIOD_FRAMES = PER_W'(64);
	localparam logic [FRAC_W-1:0]  RST_REMAINDER     = FRAC_W'(64 * TICKS_PER_SECOND);

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_FRAMES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_FRAMES = 2'd2;

	localparam logic [FUNC_W-1:0] FUNC_QUERY    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CALLBACK = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_POS_DIV,
		ST_PER_DIV,
		ST_FRM_DIV,
		ST_RATE_DIV,
		ST_OUT
	} ppt_state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} ppt_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DVS_W-1:0] remainder;
	} ppt_div_rsp_t;

endpackage

// ----- hdl/ppt_ifs.sv -----
interface ppt_in_if;
	import ppt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [TICKS_W-1:0]   delta_ticks;

	modport source (output valid, output func, output delta_ticks, input ready);
	modport sink (input valid, input func, input delta_ticks, output ready);
endinterface

interface ppt_out_if;
	import ppt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [POS_W-1:0]     position;
	logic [PEND_W-1:0]    periods_elapsed;
	logic                 period_event;
	logic [REARM_W-1:0]   rearm_ticks;

	modport source (output valid, output position, output periods_elapsed,
		output period_event, output rearm_ticks, input ready);
	modport sink (input valid, input position, input periods_elapsed,
		input period_event, input rearm_ticks, output ready);
endinterface

// ----- hdl/ppt_div.sv -----
module ppt_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ppt_pkg::ppt_div_req_t req,
	output ppt_pkg::ppt_div_rsp_t rsp
);
	import ppt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     den_q;

	logic [DVS_W:0]       trial;
	logic [DVS_W:0]       diff;
	logic                 step_bit;
	logic [DVS_W-1:0]     step_rem;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial    = {rem_q, quo_q[DVD_W-1]};
		diff     = trial - {1'b0, den_q};
		step_bit = (trial >= {1'b0, den_q});
		step_rem = step_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], step_bit};
			rem_q <= step_rem;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- hdl/pcm_period_position_tracker_top.sv -----
// audio buffer position and period tracker
// in_item carries func (query, callback, restart) and the ticks elapsed since the
// last update; every accepted item gives exactly one out_item.
// configuration: cfg_we writes cfg_data into register cfg_index (0 sample rate,
// 1 buffer frames, 2 period frames); write only while no item is in flight.
// one item at a time: in_item.ready is high only while the sequencer is idle.
// all division goes through one shared radix-2 divider; an item makes up to
// four passes.
// path from accept to out_item.valid:
//   restart                       straight to the output
//   query or callback, zero ticks frame division (callback adds rate division)
//   query with ticks              multiply, position division, frame division
//   callback with ticks           as query with ticks, then rate division
// crossing a period boundary adds a period division after the position pass.
// the result register holds while out_item.ready is low; no new item is taken
// until the result is delivered.
// reset restores the register defaults, clears the position and pending count
// and loads one full period into the remainder; no clearing pass is needed.
module pcm_period_position_tracker_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppt_pkg::CFG_W-1:0]      cfg_data,
	ppt_in_if.sink                         in_item,
	ppt_out_if.source                      out_item
);
	import ppt_pkg::*;

	ppt_state_t state_q;
	ppt_state_t state_d;

	logic [RATE_W-1:0]  rate_q;
	logic [BUF_W-1:0]   buf_q;
	logic [PER_W-1:0]   per_q;

	logic [FRAC_W-1:0]  pos_q;
	logic [FRAC_W-1:0]  rem_q;
	logic [PEND_W-1:0]  pend_q;

	logic [FUNC_W-1:0]  func_q;
	logic [AMT_W-1:0]   amount_q;
	logic [POS_W-1:0]   position_q;
	logic [PEND_W-1:0]  elapsed_q;
	logic               event_q;
	logic [REARM_W-1:0] rearm_q;

	logic [RATE_W-1:0]  rate_eff;
	logic [BUF_W-1:0]   buf_eff;
	logic [PER_W-1:0]   per_eff;
	logic [DVS_W-1:0]   buf_frac;
	logic [PFRAC_W-1:0] per_frac;

	logic               in_acc;
	logic               rem_le;
	logic [FRAC_W-1:0]  rem_sub;
	logic [DVD_W:0]     pend_sum;
	logic [PEND_W-1:0]  pend_sat;

	ppt_div_req_t div_req;
	ppt_div_rsp_t div_rsp;

	ppt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
		buf_eff  = (buf_q == '0) ? BUF_W'(1) : ((buf_q > BUF_MAX) ? BUF_MAX : buf_q);
		per_eff  = (per_q == '0) ? PER_W'(1) : per_q;
		buf_frac = DVS_W'(buf_eff * TICKS_PER_SECOND);
		per_frac = PFRAC_W'(per_eff * TICKS_PER_SECOND);
		in_acc   = in_item.valid && in_item.ready;
		rem_le   = ({1'b0, rem_q} <= amount_q);
		rem_sub  = FRAC_W'({1'b0, rem_q} - amount_q);
		pend_sum = (DVD_W+1)'(pend_q) + (DVD_W+1)'(div_rsp.quotient) + 1'b1;
		pend_sat = (pend_sum > (DVD_W+1)'({PEND_W{1'b1}})) ? {PEND_W{1'b1}}
			: pend_sum[PEND_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_item.func == FUNC_RESTART) begin
						state_d = ST_OUT;
					end else if (in_item.delta_ticks != '0) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_FRM_DIV;
					end
				end
			end
			ST_MUL: begin
				state_d = ST_POS_DIV;
			end
			ST_POS_DIV: begin
				if (div_rsp.done) begin
					state_d = rem_le ? ST_PER_DIV : ST_FRM_DIV;
				end
			end
			ST_PER_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_FRM_DIV;
				end
			end
			ST_FRM_DIV: begin
				if (div_rsp.done) begin
					state_d = (func_q == FUNC_CALLBACK) ? ST_RATE_DIV : ST_OUT;
				end
			end
			ST_RATE_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_item.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// launch the shared divider on entry to a division state
		if (state_d != state_q) begin
			case (state_d)
				ST_POS_DIV: begin
					div_req.start    = 1'b1;
					div_req.dividend = DVD_W'(pos_q) + DVD_W'(amount_q);
					div_req.divisor  = buf_frac;
				end
				ST_PER_DIV: begin
					div_req.start    = 1'b1;
					div_req.dividend = DVD_W'(amount_q) - DVD_W'(rem_q);
					div_req.divisor  = DVS_W'(per_frac);
				end
				ST_FRM_DIV: begin
					div_req.start    = 1'b1;
					div_req.dividend = (state_q == ST_POS_DIV) ? DVD_W'(div_rsp.remainder)
						: DVD_W'(pos_q);
					div_req.divisor  = DVS_W'(TICKS_PER_SECOND);
				end
				ST_RATE_DIV: begin
					div_req.start    = 1'b1;
					div_req.dividend = DVD_W'(rem_q) + DVD_W'(rate_eff) - 1'b1;
					div_req.divisor  = DVS_W'(rate_eff);
				end
				default: begin
					div_req.start = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RST_SAMPLE_RATE;
			buf_q  <= RST_BUFFER_FRAMES;
			per_q  <= RST_PERIOD_FRAMES;
			pos_q  <= '0;
			rem_q  <= RST_REMAINDER;
			pend_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_RATE:   rate_q <= cfg_data[RATE_W-1:0];
					CFG_BUFFER_FRAMES: buf_q  <= cfg_data[BUF_W-1:0];
					CFG_PERIOD_FRAMES: per_q  <= cfg_data[PER_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_item.func == FUNC_RESTART) begin
						pos_q  <= '0;
						rem_q  <= FRAC_W'(per_frac);
						pend_q <= '0;
					end
				end
				ST_POS_DIV: begin
					if (div_rsp.done) begin
						pos_q <= FRAC_W'(div_rsp.remainder);
						if (!rem_le) begin
							rem_q <= rem_sub;
						end
					end
				end
				ST_PER_DIV: begin
					// new remainder is one period less the overshoot into it
					if (div_rsp.done) begin
						rem_q  <= FRAC_W'(per_frac - div_rsp.remainder[PFRAC_W-1:0]);
						pend_q <= pend_sat;
					end
				end
				ST_RATE_DIV: begin
					if (div_rsp.done) begin
						pend_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q     <= in_item.func;
			amount_q   <= AMT_W'(in_item.delta_ticks) * AMT_W'(rate_eff);
			position_q <= '0;
			elapsed_q  <= '0;
			event_q    <= 1'b0;
			rearm_q    <= '0;
		end else if (div_rsp.done) begin
			if (state_q == ST_FRM_DIV) begin
				position_q <= div_rsp.quotient[POS_W-1:0];
			end
			if (state_q == ST_RATE_DIV) begin
				elapsed_q <= pend_q;
				event_q   <= (pend_q != '0);
				rearm_q   <= div_rsp.quotient[REARM_W-1:0];
			end
		end
	end

	assign in_item.ready            = (state_q == ST_IDLE);
	assign out_item.valid           = (state_q == ST_OUT);
	assign out_item.position        = position_q;
	assign out_item.periods_elapsed = elapsed_q;
	assign out_item.period_event    = event_q;
	assign out_item.rearm_ticks     = rearm_q;

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> rem_q != '0)
		else $error("period remainder is zero while idle");

	a_event_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_item.valid |-> out_item.period_event == (out_item.periods_elapsed != '0))
		else $error("period event disagrees with elapsed count");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_POS_DIV || state_q == ST_PER_DIV ||
			state_q == ST_FRM_DIV || state_q == ST_RATE_DIV))
		else $error("divider finished outside a division state");

	a_pos_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POS_DIV && div_rsp.done) |=> pos_q < FRAC_W'(buf_frac))
		else $error("position not reduced below buffer size");

endmodule
